// ----- rtl/lkv_pkg.sv -----
package lkv_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_W   = IDX_W;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      REQ_GET = 1'b0,
      REQ_SET = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type           kind;
      logic [KEY_W-1:0]       key;
      logic [VAL_W-1:0]       value;
   } request_type;

   typedef struct packed {
      logic                   hit;
      logic [VAL_W-1:0]       value;
   } result_type;

endpackage

// ----- rtl/lkv_if.sv -----
interface lkv_req_if;
   logic                              valid;
   logic                              ready;
   logic                              req_type;
   logic signed [lkv_pkg::KEY_W-1:0]  lookup_key;
   logic signed [lkv_pkg::VAL_W-1:0]  write_value;

   modport source (output valid, output req_type, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input req_type, input lookup_key, input write_value,
                   output ready);
endinterface

interface lkv_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic signed [lkv_pkg::VAL_W-1:0]  read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkv_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lkv_pkg::CAP_W-1:0]         data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lkv_req_reg.sv -----
module lkv_req_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  lkv_pkg::request_type  in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output lkv_pkg::request_type  out_data,
   input  logic                  out_take
);
   import lkv_pkg::*;

   logic        valid_ff, valid_in;
   request_type data_ff;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ----- rtl/lkv_store.sv -----
module lkv_store (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  lkv_pkg::request_type        req,
   input  logic [lkv_pkg::CNT_W-1:0]   cap,
   output lkv_pkg::result_type         res
);
   import lkv_pkg::*;

   logic [CAPACITY-1:0]  valid_ff, valid_in;
   logic [KEY_W-1:0]     key_ff   [CAPACITY];
   logic [KEY_W-1:0]     key_in   [CAPACITY];
   logic [VAL_W-1:0]     value_ff [CAPACITY];
   logic [VAL_W-1:0]     value_in [CAPACITY];
   logic [RANK_W-1:0]    rank_ff  [CAPACITY];
   logic [RANK_W-1:0]    rank_in  [CAPACITY];
   logic [CNT_W-1:0]     count_ff, count_in;

   logic [CAPACITY-1:0]  match, victim, valid_after, free, slot;
   logic                 hit, evict, insert;
   logic [RANK_W-1:0]    hit_rank, oldest_rank;
   logic [VAL_W-1:0]     hit_value;

   // ranks of valid entries are always 0 .. count-1, so the oldest has count-1
   assign oldest_rank = RANK_W'(count_ff - CNT_W'(1));

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == req.key);
         victim[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
         hit_rank  = hit_rank  | (match[i] ? rank_ff[i]  : '0);
         hit_value = hit_value | (match[i] ? value_ff[i] : '0);
      end
   end

   assign hit         = |match;
   assign insert      = (req.kind == REQ_SET) && !hit;
   assign evict       = insert && (count_ff >= cap);
   assign valid_after = valid_ff & ~(evict ? victim : '0);
   assign free        = ~valid_after;
   assign slot        = free & (~free + CAPACITY'(1));

   assign res.hit   = hit;
   assign res.value = ((req.kind == REQ_GET) && hit) ? hit_value : MISS_VALUE;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (fire) begin
         if (hit) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (match[i]) begin
                  rank_in[i] = '0;
                  if (req.kind == REQ_SET) begin
                     value_in[i] = req.value;
                  end
               end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end else if (insert) begin
            valid_in = valid_after | slot;
            if (!evict) begin
               count_in = count_ff + CNT_W'(1);
            end
            for (int i = 0; i < CAPACITY; i++) begin
               if (slot[i]) begin
                  rank_in[i]  = '0;
                  key_in[i]   = req.key;
                  value_in[i] = req.value;
               end else if (valid_after[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
      end
   end

endmodule

// ----- rtl/lkv_rsp_reg.sv -----
module lkv_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_load,
   input  lkv_pkg::result_type  in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   output lkv_pkg::result_type  out_data,
   input  logic                 out_ready
);
   import lkv_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         data_ff <= in_data;
      end
   end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// a request beat is held in the request register; its result beat is then presented from the result register
// throughput: one request per cycle while the result register can load; lookup, rank update and fill happen in a single
// pass between the request register and the result register
// reset: all entries invalid, fill count zero, capacity register back to 16
// the capacity port is always ready and takes effect on the next request
module lru_key_value_cache (
   input  logic      clock,
   input  logic      reset,
   lkv_req_if.sink   req_bus,
   lkv_rsp_if.source rsp_bus,
   lkv_csr_if.sink   csr_bus
);
   import lkv_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] eff_cap;

   request_type req_in_data, req_data;
   result_type  result, rsp_data;
   logic        req_valid, rsp_can_load, fire;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_bus.valid) begin
         cap_ff <= csr_bus.data;
      end
   end

   // clamp to 1 .. CAPACITY
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (int'(cap_ff) > CAPACITY) begin
         eff_cap = CNT_W'(CAPACITY);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign req_in_data.kind  = req_kind_type'(req_bus.req_type);
   assign req_in_data.key   = req_bus.lookup_key;
   assign req_in_data.value = req_bus.write_value;

   assign fire = req_valid && rsp_can_load;

   lkv_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_data   (req_in_data),
      .in_ready  (req_bus.ready),
      .out_valid (req_valid),
      .out_data  (req_data),
      .out_take  (fire)
   );

   lkv_store u_store (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_data),
      .cap   (eff_cap),
      .res   (result)
   );

   lkv_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_load   (fire),
      .in_data   (result),
      .in_ready  (rsp_can_load),
      .out_valid (rsp_bus.valid),
      .out_data  (rsp_data),
      .out_ready (rsp_bus.ready)
   );

   assign rsp_bus.hit        = rsp_data.hit;
   assign rsp_bus.read_value = signed'(rsp_data.value);

endmodule
